// ----- hw/rtl/kbm_pkg.sv -----
// Shared types, codes and default sizes of the keyword bitmask matcher.
package kbm_pkg;

  localparam int KEYWORDS_DEF        = 64;
  localparam int MAX_KEYWORD_LEN_DEF = 15;
  localparam int ID_BITS_DEF         = 16;

  // command codes
  localparam logic [1:0] CMD_WR_CHAR = 2'd0;
  localparam logic [1:0] CMD_WR_LEN  = 2'd1;
  localparam logic [1:0] CMD_SCAN    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_MATCH      = 2'd0;
  localparam logic [1:0] ST_NO_KEYWORD = 2'd1;
  localparam logic [1:0] ST_NOT_IDENT  = 2'd2;

  // configuration register indexes
  localparam logic REG_KEYWORD_COUNT = 1'b0;
  localparam logic REG_IGNORE_CASE   = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  keyword_index;
    logic [3:0]  char_position;
    logic [7:0]  char_value;
    logic [3:0]  keyword_length;
    logic [15:0] keyword_ident;
    logic        token_start;
  } kbm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] matched_id;
  } kbm_out_t;

  typedef struct packed {
    logic       index;
    logic [6:0] data;
  } kbm_cfg_t;

endpackage

// ----- hw/rtl/kbm_stream_if.sv -----
// Valid/ready channel carrying one payload word.
interface kbm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/kbm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the entry written in the same cycle sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/keyword_bitmask_matcher_core.sv -----
// Keyword bitmask matcher: one keyword-char memory per lane, scan pipeline and result register.
// Takes one word per cycle, load or scan alike, unless a result stalls at the output. Each
// keyword has its own small character memory, addressed by position, so every scan word reads
// all keywords' characters at the current position in one read; the next position is known
// when a word is taken, so the read is issued at acceptance and the candidate mask is narrowed
// as the word leaves the match stage. A terminating or refused character's result passes the
// match stage register, then the output register with the id memory read. Tables are undefined
// until loaded; there is no clearing pass after reset. Configuration writes are taken at once.
module keyword_bitmask_matcher_core #(
  parameter int KEYWORDS        = kbm_pkg::KEYWORDS_DEF,
  parameter int MAX_KEYWORD_LEN = kbm_pkg::MAX_KEYWORD_LEN_DEF,
  parameter int ID_BITS         = kbm_pkg::ID_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  kbm_stream_if.sink   in_if,
  kbm_stream_if.source out_if,
  kbm_stream_if.sink   cfg_if
);
  import kbm_pkg::*;

  localparam int KW_W   = (KEYWORDS > 1) ? $clog2(KEYWORDS) : 1;
  localparam int POS_W  = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int ADDR_W = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
  localparam int CMP_W  = (POS_W > 4) ? POS_W : 4;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_CONT   = 2'd1;
  localparam logic [1:0] KIND_TERM   = 2'd2;
  localparam logic [1:0] KIND_REFUSE = 2'd3;

  // configuration
  logic [6:0] kw_count_r;
  logic       ignore_case_r;

  // acceptance stage state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             in_token_r, in_token_nxt;

  // match stage
  logic             b_valid_r, b_valid_nxt;
  logic [1:0]       b_kind_r, b_kind_nxt;
  logic [POS_W-1:0] b_pos_r;
  logic [7:0]       b_char_r;
  logic [KEYWORDS-1:0] mask_r, mask_nxt;

  // output register
  logic       out_valid_r;
  logic [1:0] out_status_r;

  logic [3:0]         len_r [KEYWORDS];
  logic [7:0]         kw_rdata [KEYWORDS];
  logic [ID_BITS-1:0] id_rdata;

  logic in_accept, is_scan, wr_char, wr_len, kidx_ok;
  logic c_start, c_cont;
  logic [POS_W-1:0] cur_pos;
  logic [7:0] c_fold;
  logic b_res, b_go, out_free, id_re;
  logic [KEYWORDS-1:0] hit, lhit, term_mask;
  logic [KW_W-1:0] first_idx;
  logic [1:0] res_status;

  kbm_in_t in_w;
  assign in_w = in_if.payload;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    return (en && c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
    return (p < POS_W'(MAX_KEYWORD_LEN)) ? p + POS_W'(1) : p;
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_count_r    <= '0;
      ignore_case_r <= 1'b0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.payload.index)
        REG_KEYWORD_COUNT: kw_count_r    <= cfg_if.payload.data;
        REG_IGNORE_CASE:   ignore_case_r <= cfg_if.payload.data[0];
      endcase
    end
  end

  // ---------------------------------------------------------------- accept stage
  assign out_free  = !out_valid_r || out_if.ready;
  assign b_res     = (b_kind_r == KIND_TERM) || (b_kind_r == KIND_REFUSE);
  assign b_go      = b_valid_r && (!b_res || out_free);
  assign in_if.ready = !b_valid_r || b_go;
  assign in_accept = in_if.valid && in_if.ready;

  assign kidx_ok = int'(in_w.keyword_index) < KEYWORDS;
  assign wr_char = in_accept && (in_w.cmd == CMD_WR_CHAR) && kidx_ok &&
                   (int'(in_w.char_position) < MAX_KEYWORD_LEN);
  assign wr_len  = in_accept && (in_w.cmd == CMD_WR_LEN) && kidx_ok;
  assign is_scan = in_accept && (in_w.cmd == CMD_SCAN);

  assign c_start = is_letter(in_w.char_value) || in_w.char_value == 8'h5f;
  assign c_cont  = c_start || (in_w.char_value >= 8'h30 && in_w.char_value <= 8'h39);
  assign cur_pos = in_w.token_start ? '0 : pos_r;
  assign c_fold  = fold(in_w.char_value, ignore_case_r);

  always_comb begin
    pos_nxt      = pos_r;
    in_token_nxt = in_token_r;
    b_kind_nxt   = KIND_START;
    b_valid_nxt  = b_go ? 1'b0 : b_valid_r;
    if (is_scan) begin
      if (in_w.token_start) begin
        b_valid_nxt = 1'b1;
        if (c_start) begin
          b_kind_nxt   = KIND_START;
          pos_nxt      = sat_inc('0);
          in_token_nxt = 1'b1;
        end else begin
          b_kind_nxt   = KIND_REFUSE;
          pos_nxt      = '0;
          in_token_nxt = 1'b0;
        end
      end else if (in_token_r) begin
        b_valid_nxt = 1'b1;
        if (c_cont) begin
          b_kind_nxt = KIND_CONT;
          pos_nxt    = sat_inc(pos_r);
        end else begin
          b_kind_nxt   = KIND_TERM;
          in_token_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      in_token_r <= 1'b0;
      b_valid_r  <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      in_token_r <= in_token_nxt;
      b_valid_r  <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_kind_r <= b_kind_nxt;
      b_pos_r  <= cur_pos;
      b_char_r <= c_fold;
    end
  end

  // one character memory and one length register per keyword lane
  for (genvar k = 0; k < KEYWORDS; k++) begin : g_lane
    logic [7:0] s_fold;
    logic       lane_on;

    kbm_ram #(
      .WIDTH (8),
      .DEPTH (MAX_KEYWORD_LEN)
    ) u_char_ram (
      .clk   (clk),
      .we    (wr_char && int'(in_w.keyword_index) == k),
      .waddr (ADDR_W'(in_w.char_position)),
      .wdata (in_w.char_value),
      .re    (is_scan),
      .raddr (ADDR_W'(cur_pos)),
      .rdata (kw_rdata[k])
    );

    always_ff @(posedge clk) begin
      if (wr_len && int'(in_w.keyword_index) == k) begin
        len_r[k] <= in_w.keyword_length;
      end
    end

    assign s_fold  = fold(kw_rdata[k], ignore_case_r);
    assign lane_on = (7'(k) < kw_count_r) &&
                     (CMP_W'(len_r[k]) <= CMP_W'(MAX_KEYWORD_LEN));
    assign hit[k]  = lane_on && (CMP_W'(len_r[k]) > CMP_W'(b_pos_r)) &&
                     (s_fold == b_char_r);
    assign lhit[k] = lane_on && (CMP_W'(len_r[k]) == CMP_W'(b_pos_r));
  end

  // ---------------------------------------------------------------- match stage
  assign term_mask = mask_r & lhit;

  always_comb begin
    first_idx = '0;
    for (int k = KEYWORDS - 1; k >= 0; k--) begin
      if (term_mask[k]) begin
        first_idx = KW_W'(k);
      end
    end
  end

  always_comb begin
    mask_nxt   = mask_r;
    res_status = ST_NO_KEYWORD;
    if (b_go) begin
      unique case (b_kind_r)
        KIND_START:  mask_nxt = hit;
        KIND_CONT:   mask_nxt = mask_r & hit;
        KIND_TERM:   mask_nxt = term_mask;
        KIND_REFUSE: mask_nxt = '0;
      endcase
    end
    if (b_kind_r == KIND_REFUSE) begin
      res_status = ST_NOT_IDENT;
    end else if (term_mask != '0) begin
      res_status = ST_MATCH;
    end
  end

  assign id_re = b_go && (b_kind_r == KIND_TERM) && (term_mask != '0);

  kbm_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (KEYWORDS)
  ) u_id_ram (
    .clk   (clk),
    .we    (wr_len),
    .waddr (KW_W'(in_w.keyword_index)),
    .wdata (ID_BITS'(in_w.keyword_ident)),
    .re    (id_re),
    .raddr (first_idx),
    .rdata (id_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_go && b_res) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_res) begin
      out_status_r <= res_status;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.payload.status = out_status_r;
  // id memory read data holds until the next match word is loaded
  assign out_if.payload.matched_id = (out_status_r == ST_MATCH) ? 16'(id_rdata) : 16'd0;

  // ---------------------------------------------------------------- checks
  a_token_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_token_r |-> pos_r != '0)
    else $error("open token with position zero");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    b_go && b_res |=> out_valid_r)
    else $error("result word lost at output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |-> !(b_go && b_res))
    else $error("result overwrites a waiting word");

  a_match_read: assert property (@(posedge clk) disable iff (!rst_n)
    b_go && b_res && res_status == ST_MATCH |-> id_re)
    else $error("match without id read");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the keyword bitmask matcher core.
`timescale 1ns / 100ps

module tb_top;
  import kbm_pkg::*;

  localparam int NKW = KEYWORDS_DEF;
  localparam int MAXLEN = MAX_KEYWORD_LEN_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE = 4;
  localparam int PHASE_ITEMS = 28;
  localparam bit [7:0] KW_ALPHA [6] = '{"a", "A", "b", "B", "_", "1"};
  localparam int PH_COUNT [6] = '{64, 37, 127, 1, 0, 65};
  localparam bit PH_FOLD [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

  // Own copy of the keyword tables and scan state; expected verdicts queue up here.
  class verdict_board;
    bit [7:0]  kw_text [NKW][MAXLEN];
    bit [3:0]  kw_len [NKW];
    bit [15:0] kw_id [NKW];
    bit [63:0] cand;
    int unsigned pos;
    bit in_tok;
    bit [6:0] kw_count;
    bit fold_case;
    kbm_out_t due [$];
    int errors;

    static function bit is_letter(bit [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    static function bit starts_ident(bit [7:0] c);
      return is_letter(c) || c == "_";
    endfunction

    static function bit continues_ident(bit [7:0] c);
      return starts_ident(c) || (c >= "0" && c <= "9");
    endfunction

    function bit [7:0] fold_char(bit [7:0] c);
      if (fold_case && c >= "a" && c <= "z") return c - 8'h20;
      return c;
    endfunction

    function int active();
      return (kw_count > NKW) ? NKW : int'(kw_count);
    endfunction

    function bit [63:0] hit_mask(bit [7:0] c);
      bit [63:0] m;
      m = '0;
      for (int k = 0; k < active(); k++)
        if (pos < kw_len[k] && fold_char(kw_text[k][pos]) == fold_char(c)) m[k] = 1'b1;
      return m;
    endfunction

    function bit [63:0] len_mask();
      bit [63:0] m;
      m = '0;
      for (int k = 0; k < active(); k++)
        if (kw_len[k] == pos) m[k] = 1'b1;
      return m;
    endfunction

    function void scan_char(bit [7:0] c, bit first);
      kbm_out_t v;
      v.matched_id = '0;
      if (first) begin
        pos = 0;
        if (!starts_ident(c)) begin
          in_tok = 1'b0;
          cand = '0;
          v.status = ST_NOT_IDENT;
          due.push_back(v);
          return;
        end
        cand = hit_mask(c);
        in_tok = 1'b1;
        if (pos < MAXLEN) pos++;
        return;
      end
      if (!in_tok) return;
      if (continues_ident(c)) begin
        cand &= hit_mask(c);
        if (pos < MAXLEN) pos++;
        return;
      end
      // terminator: only keywords ending exactly here survive, char not consumed
      cand &= len_mask();
      in_tok = 1'b0;
      if (cand == '0) begin
        v.status = ST_NO_KEYWORD;
      end else begin
        v.status = ST_MATCH;
        for (int k = 0; k < NKW; k++)
          if (cand[k]) begin
            v.matched_id = kw_id[k];
            break;
          end
      end
      due.push_back(v);
    endfunction

    function void note_word(kbm_in_t w);
      case (w.cmd)
        CMD_WR_CHAR: begin
          if (w.char_position < MAXLEN) kw_text[w.keyword_index][w.char_position] = w.char_value;
        end
        CMD_WR_LEN: begin
          kw_len[w.keyword_index] = w.keyword_length;
          kw_id[w.keyword_index] = w.keyword_ident;
        end
        CMD_SCAN: scan_char(w.char_value, w.token_start);
        default: ;
      endcase
    endfunction

    function void set_reg(kbm_cfg_t r);
      case (r.index)
        REG_KEYWORD_COUNT: kw_count = r.data;
        REG_IGNORE_CASE: fold_case = r.data[0];
        default: ;
      endcase
    endfunction

    function void check_result(kbm_out_t got);
      kbm_out_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d id %h", got.status, got.matched_id);
        return;
      end
      want = due.pop_front();
      if (got.status !== want.status || got.matched_id !== want.matched_id) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: status exp %0d got %0d, id exp %h got %h",
                   want.status, got.status, want.matched_id, got.matched_id);
      end
    endfunction

    function void close();
      if (due.size() != 0) begin
        errors += due.size();
        $display("%0d results never arrived", due.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  kbm_stream_if #(.payload_t(kbm_in_t)) in_ch ();
  kbm_stream_if #(.payload_t(kbm_out_t)) out_ch ();
  kbm_stream_if #(.payload_t(kbm_cfg_t)) cfg_ch ();

  keyword_bitmask_matcher_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  verdict_board sb = new();

  // stimulus-side mirror of what has been loaded, used to build scans
  bit [7:0] gen_txt [NKW][MAXLEN];
  bit [3:0] gen_len [NKW];
  bit wrote [NKW][MAXLEN];
  int cur_count = 0;
  int items_sent = 0;
  int send_idle = 0;
  int recv_idle = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
      if (in_ch.valid && in_ch.ready) sb.note_word(in_ch.payload);
      if (cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.payload);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[keyword_bitmask_matcher_core] ERROR");
    $finish;
  end

  function automatic kbm_in_t random_word();
    bit [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(kbm_in_t)-1:0];
  endfunction

  function automatic kbm_in_t scan_word(bit [7:0] c, bit first);
    kbm_in_t w;
    w = random_word();
    w.cmd = CMD_SCAN;
    w.char_value = c;
    w.token_start = first;
    return w;
  endfunction

  function automatic bit [7:0] ident_char(bit first);
    bit [7:0] c;
    if ($urandom_range(9) < 7) return KW_ALPHA[$urandom_range(first ? 4 : 5)];
    do c = 8'($urandom()); while (!(first ? verdict_board::starts_ident(c)
                                          : verdict_board::continues_ident(c)));
    return c;
  endfunction

  function automatic bit [7:0] end_char();
    bit [7:0] c;
    do c = 8'($urandom()); while (verdict_board::continues_ident(c));
    return c;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(15);
    if (r == 0) return MAXLEN;
    if (r == 1) return 0;
    return $urandom_range(1, 5);
  endfunction

  function automatic int prefix_len(int k);
    int n;
    n = 0;
    while (n < MAXLEN && wrote[k][n]) n++;
    return n;
  endfunction

  task automatic drive_word(input kbm_in_t w);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= w;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // hold off the sender until every pending verdict is back, plus pipeline drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    // the last accepted word is noted at the same edge, so look from the next one on
    do @(posedge clk); while (sb.due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input int count, input bit fold);
    kbm_cfg_t r;
    drain();
    r.index = REG_KEYWORD_COUNT;
    r.data = 7'(count);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= r;
    do @(posedge clk); while (!cfg_ch.ready);
    r.index = REG_IGNORE_CASE;
    r.data = {6'($urandom()), fold};
    cfg_ch.payload <= r;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_count = count;
  endtask

  task automatic send_chars(input bit [7:0] q[$]);
    foreach (q[i]) drive_word(scan_word(q[i], i == 0));
  endtask

  // chars first, then length, so an in-use keyword never reads an unwritten char
  task automatic load_keyword(input int k, input int len, input int like);
    kbm_in_t w;
    if (like >= 0) len = gen_len[like];
    for (int p = 0; p < len; p++) begin
      w = random_word();
      w.cmd = CMD_WR_CHAR;
      w.keyword_index = 6'(k);
      w.char_position = 4'(p);
      if (like >= 0) w.char_value = gen_txt[like][p];
      else if ($urandom_range(19) == 0) w.char_value = 8'($urandom());
      else w.char_value = ident_char(p == 0);
      drive_word(w);
      gen_txt[k][p] = w.char_value;
      wrote[k][p] = 1'b1;
    end
    w = random_word();
    w.cmd = CMD_WR_LEN;
    w.keyword_index = 6'(k);
    w.keyword_length = 4'(len);
    drive_word(w);
    gen_len[k] = 4'(len);
  endtask

  task automatic run_token();
    bit [7:0] q[$];
    bit [7:0] c;
    int r, k, n, active;
    kbm_in_t w;
    active = (cur_count > NKW) ? NKW : cur_count;
    r = $urandom_range(99);
    k = (active > 0) ? $urandom_range(active - 1) : 0;
    if (r < 50 || (r >= 80 && r < 88)) begin
      for (int p = 0; p < gen_len[k]; p++) begin
        c = gen_txt[k][p];
        if (verdict_board::is_letter(c) && $urandom_range(1)) c ^= 8'h20;
        q.push_back(c);
      end
      if (r >= 80) begin
        // cut short: the next token start abandons it
        if (q.size() > 1) void'(q.pop_back());
        send_chars(q);
        return;
      end
      n = $urandom_range(19);
      if (n == 0 && q.size() > 0) void'(q.pop_back());
      else if (n == 1) q.push_back(ident_char(1'b0));
      q.push_back(end_char());
      send_chars(q);
    end else if (r < 65) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) q.push_back(ident_char(i == 0));
      q.push_back(end_char());
      send_chars(q);
    end else if (r < 73) begin
      do c = 8'($urandom()); while (verdict_board::starts_ident(c));
      drive_word(scan_word(c, 1'b1));
    end else if (r < 80) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) drive_word(scan_word(8'($urandom()), 1'b0));
    end else begin
      w = random_word();
      case ($urandom_range(3))
        0: begin
          w.cmd = CMD_UNUSED;
          drive_word(w);
        end
        1: begin
          w.cmd = CMD_WR_CHAR;
          w.char_position = 4'(MAXLEN);
          drive_word(w);
        end
        2: load_keyword($urandom_range(NKW - 1), pick_len(), -1);
        default: begin
          n = $urandom_range(NKW - 1);
          w.cmd = CMD_WR_LEN;
          w.keyword_index = 6'(n);
          w.keyword_length = 4'($urandom_range(prefix_len(n)));
          drive_word(w);
          gen_len[n] = w.keyword_length;
        end
      endcase
    end
  endtask

  initial begin
    bit [7:0] q[$];
    kbm_in_t w;
    int stop;
    bit paused;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.payload <= '0;
    rst_n <= 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // no keywords in use yet: refused starts, stray scan, plain identifier
    drive_word(scan_word(8'h00, 1'b1));
    drive_word(scan_word(8'hFF, 1'b1));
    drive_word(scan_word("9", 1'b1));
    drive_word(scan_word("a", 1'b0));
    q = '{"_", "z", 8'h80};
    send_chars(q);

    // keyword 5 is full length, keyword 7 duplicates keyword 3
    for (int k = 0; k < NKW; k++)
      load_keyword(k, (k == 5) ? MAXLEN : pick_len(), (k == 7) ? 3 : -1);
    write_regs(NKW, 1'b1);

    q.delete();
    for (int p = 0; p < gen_len[3]; p++)
      q.push_back(verdict_board::is_letter(gen_txt[3][p]) ? gen_txt[3][p] ^ 8'h20
                                                          : gen_txt[3][p]);
    q.push_back(" ");
    send_chars(q);
    q.delete();
    for (int p = 0; p < gen_len[2]; p++) q.push_back(gen_txt[2][p]);
    send_chars(q);
    q.delete();
    for (int p = 0; p < gen_len[1]; p++) q.push_back(gen_txt[1][p]);
    q.push_back("(");
    send_chars(q);
    w = '1;
    drive_word(w);
    w.cmd = CMD_WR_CHAR;
    drive_word(w);

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 20 : (ph < 4) ? 52 : 0;
      recv_idle = (ph < 2) ? 52 : (ph < 4) ? 20 : 0;
      write_regs(PH_COUNT[ph], PH_FOLD[ph]);
      stop = items_sent + PHASE_ITEMS;
      while (items_sent < stop) begin
        run_token();
        if (ph == 2 && !paused && items_sent >= stop - PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    sb.close();
    if (sb.errors == 0)
      $display("[keyword_bitmask_matcher_core] OK");
    else
      $display("[keyword_bitmask_matcher_core] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/kbm_pkg.sv
hw/rtl/kbm_stream_if.sv
hw/rtl/kbm_ram.sv
hw/rtl/keyword_bitmask_matcher_core.sv
test/tb_top.sv
